### hw/rtl/aabb_pkg.sv
// Shared operation codes, status codes and controller states of the box table.
package aabb_pkg;

    // Operation selector carried in the input tuser
    localparam int OP_BITS = 2;
    typedef logic [OP_BITS-1:0] t_op;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_QUERY  = 2'd2;

    // Result status
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Table controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/aabb_cmp.sv
// Inclusive-edge overlap test of a query box against one stored box.
module aabb_cmp #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_aw,
    input  logic signed [COORD_BITS-1:0] i_ah,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bw,
    input  logic signed [COORD_BITS-1:0] i_bh,
    output logic                         o_overlap
);

    localparam int S = COORD_BITS + 1;

    logic signed [S-1:0] ax_e, ay_e, bx_e, by_e;
    logic signed [S-1:0] a_right, a_bottom, b_right, b_bottom;
    logic                sizes_ok;

    // Sign-extend the edges and form the far edges one bit wider
    always_comb begin
        ax_e     = $signed({i_ax[COORD_BITS-1], i_ax});
        ay_e     = $signed({i_ay[COORD_BITS-1], i_ay});
        bx_e     = $signed({i_bx[COORD_BITS-1], i_bx});
        by_e     = $signed({i_by[COORD_BITS-1], i_by});
        a_right  = ax_e + $signed({i_aw[COORD_BITS-1], i_aw});
        a_bottom = ay_e + $signed({i_ah[COORD_BITS-1], i_ah});
        b_right  = bx_e + $signed({i_bw[COORD_BITS-1], i_bw});
        b_bottom = by_e + $signed({i_bh[COORD_BITS-1], i_bh});
    end

    // A box with zero or negative extent never collides
    assign sizes_ok = !i_aw[COORD_BITS-1] && (i_aw != '0) &&
                      !i_ah[COORD_BITS-1] && (i_ah != '0) &&
                      !i_bw[COORD_BITS-1] && (i_bw != '0) &&
                      !i_bh[COORD_BITS-1] && (i_bh != '0);

    assign o_overlap = sizes_ok &&
                       !(a_right < bx_e) && !(b_right < ax_e) &&
                       !(a_bottom < by_e) && !(b_bottom < ay_e);

endmodule

### hw/rtl/aabb_overlap_table.sv
// Top level of the box table: slot memory, scan controller and result register.
//
// A table of TABLE_DEPTH axis-aligned boxes held in one synchronous memory, one
// slot per word. The tuser field selects insert, remove or query; every operation
// walks the whole memory through its single read port, one slot per cycle. An
// item passes through the scan, the registered read, a write-back state and a
// result state, and tready rises again only back in the idle state, so the block
// takes no new item before it is through with the last. A stalled result holds
// the block in the result state. Removes clear matching slots as the scan passes
// them; inserts write the matching or lowest free slot after the scan. One result
// item comes back per input item and sits in an output register until taken.
// After reset the block sweeps every slot and clears it before it accepts an item.
module aabb_overlap_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // tdata from bit 0: obj_id, pos_x, pos_y, size_w, size_h, zero fill
    input  logic [((ID_BITS+4*COORD_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    // tuser: op
    input  logic [aabb_pkg::OP_BITS-1:0]                 i_s_axis_tuser,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // tdata from bit 0: hit, status, entry_count, zero fill
    output logic [((2+$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] o_m_axis_tdata
);

    import aabb_pkg::*;

    localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_DATA_W = ((2 + CNT_BITS + 7) / 8) * 8;
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic                         valid;
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] w;
        logic signed [COORD_BITS-1:0] h;
    } t_slot;

    // Slot memory and its registered read data
    t_slot r_mem [TABLE_DEPTH];
    t_slot r_rd_data;

    t_state r_state, n_state;

    // Held item
    t_op                          r_op;
    logic [ID_BITS-1:0]           r_id;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_w, r_h;

    // Scan control
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_issuing;
    logic                 r_rd_vld;
    logic [ADDR_BITS-1:0] r_rd_idx;

    // Scan results
    logic                 r_hit;
    logic                 r_status;
    logic                 r_match_found, r_free_found;
    logic [ADDR_BITS-1:0] r_match_idx, r_free_idx;
    logic [CNT_BITS-1:0]  r_count;

    // Output register
    logic                r_out_valid;
    logic                r_out_hit;
    logic                r_out_status;
    logic [CNT_BITS-1:0] r_out_count;

    // Memory write port
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    t_slot                mem_wdata;

    logic accept, out_free, id_match, box_overlap;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign id_match = r_rd_data.valid && (r_rd_data.id == r_id);

    aabb_cmp #(
        .COORD_BITS(COORD_BITS)
    ) u_cmp (
        .i_ax      (r_x),
        .i_ay      (r_y),
        .i_aw      (r_w),
        .i_ah      (r_h),
        .i_bx      (r_rd_data.x),
        .i_by      (r_rd_data.y),
        .i_bw      (r_rd_data.w),
        .i_bh      (r_rd_data.h),
        .o_overlap (box_overlap)
    );

    // Slot memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_rd_vld && (r_rd_idx == LAST_ADDR)) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Handshake and memory write controls
    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = r_rd_idx;
        mem_wdata       = r_rd_data;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                // Drop matching slots as the scan passes them
                if (r_rd_vld && (r_op == OP_REMOVE) && id_match) begin
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b0;
                end
            end
            ST_WRITE: begin
                mem_waddr = r_match_found ? r_match_idx : r_free_idx;
                mem_wdata = '{valid: 1'b1, id: r_id, x: r_x, y: r_y, w: r_w, h: r_h};
                if ((r_op == OP_INSERT) && (r_match_found || r_free_found)) begin
                    mem_we = 1'b1;
                end
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN) && r_issuing;

            // Advance the clearing sweep
            if (r_state == ST_CLEAR) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + ADDR_BITS'(1);
            end

            // Start a scan on an accepted item
            if (accept) begin
                r_addr    <= '0;
                r_issuing <= 1'b1;
            end

            // Issue one slot read per cycle
            if ((r_state == ST_SCAN) && r_issuing) begin
                if (r_addr == LAST_ADDR) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_addr <= r_addr + ADDR_BITS'(1);
                end
            end

            // Track the live count
            if ((r_state == ST_SCAN) && r_rd_vld && (r_op == OP_REMOVE) && id_match) begin
                r_count <= r_count - CNT_BITS'(1);
            end
            if ((r_state == ST_WRITE) && (r_op == OP_INSERT) &&
                !r_match_found && r_free_found) begin
                r_count <= r_count + CNT_BITS'(1);
            end

            // Hand the result to the output register
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op          <= i_s_axis_tuser;
            r_id          <= i_s_axis_tdata[0 +: ID_BITS];
            r_x           <= i_s_axis_tdata[ID_BITS +: COORD_BITS];
            r_y           <= i_s_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
            r_w           <= i_s_axis_tdata[ID_BITS + 2*COORD_BITS +: COORD_BITS];
            r_h           <= i_s_axis_tdata[ID_BITS + 3*COORD_BITS +: COORD_BITS];
            r_hit         <= 1'b0;
            r_status      <= STATUS_OK;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end

        if (r_state == ST_SCAN) begin
            r_rd_idx <= r_addr;
        end

        // Evaluate the slot read in the previous cycle
        if ((r_state == ST_SCAN) && r_rd_vld) begin
            case (r_op)
                OP_INSERT: begin
                    if (r_rd_data.valid) begin
                        if (!r_match_found && (r_rd_data.id == r_id)) begin
                            r_match_found <= 1'b1;
                            r_match_idx   <= r_rd_idx;
                        end
                    end else if (!r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_rd_idx;
                    end
                end
                OP_QUERY: begin
                    if (r_rd_data.valid && (r_rd_data.id != r_id) && box_overlap) begin
                        r_hit <= 1'b1;
                    end
                end
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end

        // Refuse an insert of a new id into a full table
        if ((r_state == ST_WRITE) && (r_op == OP_INSERT) &&
            !r_match_found && !r_free_found) begin
            r_status <= STATUS_FULL;
        end

        if ((r_state == ST_DONE) && out_free) begin
            r_out_hit    <= r_hit;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_count, r_out_status, r_out_hit});

endmodule
